// ----- src/kvlt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvlt_pkg
// Types, codes and character classes shared by the line tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kvlt_pkg;

   // Input item: one text byte or an end-of-data command.
   typedef struct packed {
      logic       command;
      logic [7:0] char_in;
   } req_type;

   // Result item: one tokenizer event.
   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] char_out;
      logic       last;
   } rsp_type;

   // Command codes.
   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Event codes.
   localparam logic [2:0] EV_NAME_CHAR  = 3'd0;
   localparam logic [2:0] EV_VALUE_CHAR = 3'd1;
   localparam logic [2:0] EV_NEXT_VALUE = 3'd2;
   localparam logic [2:0] EV_VALUES_RST = 3'd3;
   localparam logic [2:0] EV_COMMIT     = 3'd4;
   localparam logic [2:0] EV_LINE_RST   = 3'd5;

   // Parser state codes.
   localparam logic [3:0] ST_LINE_START   = 4'd0;
   localparam logic [3:0] ST_SKIP_LINE    = 4'd1;
   localparam logic [3:0] ST_IN_NAME      = 4'd2;
   localparam logic [3:0] ST_AFTER_NAME   = 4'd3;
   localparam logic [3:0] ST_BEFORE_VALUE = 4'd4;
   localparam logic [3:0] ST_IN_QUOTED    = 4'd5;
   localparam logic [3:0] ST_IN_PLAIN     = 4'd6;
   localparam logic [3:0] ST_AFTER_VALUE  = 4'd7;
   localparam logic [3:0] ST_COMMIT       = 4'd8;

   // Character constants.
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // Event chain handed from the decoder to the result queue.
   typedef struct packed {
      logic [1:0] count;
      logic [2:0] ev0;
      logic [2:0] ev1;
      logic [2:0] ev2;
      logic [7:0] ch;
      logic [3:0] next_state;
   } chain_type;

   // Letters, digits and underscore.
   function automatic logic is_name_char(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_eol(input logic [7:0] c);
      return (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

`default_nettype wire

// ----- src/kvlt_decode.sv -----
// ----------------------------------------------------------------------------
// kvlt_decode
// Next-state and event-chain decode for one byte or end command.
// ----------------------------------------------------------------------------
`default_nettype none

module kvlt_decode (
   input  kvlt_pkg::req_type   item,
   input  logic [3:0]          state,
   output kvlt_pkg::chain_type chain
);
   import kvlt_pkg::*;

   logic [7:0] c;

   assign c = item.char_in;

   // A byte that falls into skip-to-line-end is looked at again there: a line
   // end gives a line reset and goes back to line start, anything else stays.
   always_comb begin
      chain            = '0;
      chain.ch         = c;
      chain.next_state = state;
      if (item.command == CMD_END) begin
         chain.next_state = ST_LINE_START;
         if (state == ST_IN_PLAIN || state == ST_AFTER_VALUE) begin
            chain.count = 2'd2;
            chain.ev0   = EV_COMMIT;
            chain.ev1   = EV_LINE_RST;
         end else begin
            chain.count = 2'd1;
            chain.ev0   = EV_LINE_RST;
         end
      end else begin
         unique case (state) inside
            ST_LINE_START: begin
               if (c == CH_SEMI) begin
                  chain.next_state = ST_SKIP_LINE;
               end else if (is_name_char(c)) begin
                  chain.count      = 2'd1;
                  chain.ev0        = EV_NAME_CHAR;
                  chain.next_state = ST_IN_NAME;
               end
            end
            ST_SKIP_LINE: begin
               if (is_eol(c)) begin
                  chain.count      = 2'd1;
                  chain.ev0        = EV_LINE_RST;
                  chain.next_state = ST_LINE_START;
               end
            end
            ST_IN_NAME, ST_AFTER_NAME: begin
               if (is_name_char(c) && state == ST_IN_NAME) begin
                  chain.count = 2'd1;
                  chain.ev0   = EV_NAME_CHAR;
               end else if (is_blank(c)) begin
                  chain.next_state = ST_AFTER_NAME;
               end else if (c == CH_EQ) begin
                  chain.next_state = ST_BEFORE_VALUE;
               end else if (is_eol(c)) begin
                  chain.count      = 2'd1;
                  chain.ev0        = EV_LINE_RST;
                  chain.next_state = ST_LINE_START;
               end else begin
                  chain.next_state = ST_SKIP_LINE;
               end
            end
            ST_BEFORE_VALUE: begin
               if (is_name_char(c)) begin
                  // First value byte, handled as in a plain value.
                  chain.count      = 2'd1;
                  chain.ev0        = EV_VALUE_CHAR;
                  chain.next_state = ST_IN_PLAIN;
               end else if (c == CH_QUOTE) begin
                  chain.next_state = ST_IN_QUOTED;
               end else if (is_blank(c)) begin
                  chain.next_state = state;
               end else if (is_eol(c)) begin
                  // Empty value: reset values, commit, then clear the line.
                  chain.count      = 2'd3;
                  chain.ev0        = EV_VALUES_RST;
                  chain.ev1        = EV_COMMIT;
                  chain.ev2        = EV_LINE_RST;
                  chain.next_state = ST_LINE_START;
               end else begin
                  chain.next_state = ST_SKIP_LINE;
               end
            end
            ST_IN_QUOTED: begin
               if (is_eol(c)) begin
                  // Unterminated quote: the line is dropped.
                  chain.count      = 2'd1;
                  chain.ev0        = EV_LINE_RST;
                  chain.next_state = ST_LINE_START;
               end else if (c == CH_QUOTE) begin
                  chain.count      = 2'd1;
                  chain.ev0        = EV_NEXT_VALUE;
                  chain.next_state = ST_AFTER_VALUE;
               end else begin
                  chain.count = 2'd1;
                  chain.ev0   = EV_VALUE_CHAR;
               end
            end
            ST_IN_PLAIN: begin
               chain.count = 2'd1;
               if (is_eol(c)) begin
                  chain.count      = 2'd3;
                  chain.ev0        = EV_NEXT_VALUE;
                  chain.ev1        = EV_COMMIT;
                  chain.ev2        = EV_LINE_RST;
                  chain.next_state = ST_LINE_START;
               end else if (c == CH_COMMA) begin
                  chain.ev0        = EV_NEXT_VALUE;
                  chain.next_state = ST_BEFORE_VALUE;
               end else if (is_blank(c)) begin
                  chain.ev0        = EV_NEXT_VALUE;
                  chain.next_state = ST_AFTER_VALUE;
               end else begin
                  chain.ev0 = EV_VALUE_CHAR;
               end
            end
            ST_AFTER_VALUE: begin
               if (is_eol(c)) begin
                  chain.count      = 2'd2;
                  chain.ev0        = EV_COMMIT;
                  chain.ev1        = EV_LINE_RST;
                  chain.next_state = ST_LINE_START;
               end else if (is_blank(c)) begin
                  chain.next_state = state;
               end else if (c == CH_COMMA) begin
                  chain.next_state = ST_BEFORE_VALUE;
               end else begin
                  chain.next_state = ST_SKIP_LINE;
               end
            end
            ST_COMMIT: begin
               // Transient state: commit, then the byte goes to skip-line.
               chain.ev0 = EV_COMMIT;
               if (is_eol(c)) begin
                  chain.count      = 2'd2;
                  chain.ev1        = EV_LINE_RST;
                  chain.next_state = ST_LINE_START;
               end else begin
                  chain.count      = 2'd1;
                  chain.next_state = ST_SKIP_LINE;
               end
            end
            default: begin
               // Unreachable codes consume bytes silently.
               chain.next_state = state;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- src/kvlt_evq.sv -----
// ----------------------------------------------------------------------------
// kvlt_evq
// Result register for one byte's event chain; one item a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kvlt_evq (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  kvlt_pkg::chain_type chain,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kvlt_pkg::rsp_type   rsp_data
);
   import kvlt_pkg::*;

   logic [1:0] cnt_ff, cnt_in;
   logic [2:0] ev0_ff, ev1_ff, ev2_ff;
   logic [7:0] ch_ff;
   logic       pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign free      = (cnt_ff == 2'd0) || (pop && cnt_ff == 2'd1);

   // Head of the chain drives the port; only append events carry the byte.
   always_comb begin
      rsp_data.event_res = ev0_ff;
      rsp_data.char_out  = (ev0_ff == EV_NAME_CHAR || ev0_ff == EV_VALUE_CHAR) ?
                           ch_ff : 8'd0;
      rsp_data.last      = (cnt_ff == 2'd1);
   end

   // Count update: load a new chain or step down on each taken item.
   always_comb begin
      cnt_in = cnt_ff;
      if (load && free) begin
         cnt_in = chain.count;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Event slots shift toward the head as items leave.
   always_ff @(posedge clock) begin
      if (load && free) begin
         ev0_ff <= chain.ev0;
         ev1_ff <= chain.ev1;
         ev2_ff <= chain.ev2;
         ch_ff  <= chain.ch;
      end else if (pop) begin
         ev0_ff <= ev1_ff;
         ev1_ff <= ev2_ff;
      end
   end

   // A chain is only loaded when the previous one is gone or leaving.
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("event chain loaded over a pending chain");

   // A taken item of a longer chain leaves exactly one fewer behind.
   a_pop_step: assert property (@(posedge clock) disable iff (reset)
      (pop && cnt_ff > 2'd1) |=> (cnt_ff == $past(cnt_ff) - 2'd1))
      else $error("event chain count stepped wrongly");

   // The last flag marks the final item of a chain only.
   a_last_final: assert property (@(posedge clock) disable iff (reset)
      (pop && rsp_data.last && !load) |=> (cnt_ff == 2'd0))
      else $error("items remain after the last item of a chain");

endmodule

`default_nettype wire

// ----- src/key_value_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// key_value_line_tokenizer
// Byte-serial tokenizer for name=value configuration lines.
//
//   channel  direction  handshake           payload
//   req_     in         req_valid/req_stall  command, char_in
//   rsp_     out        rsp_valid/rsp_stall  event_res, char_out, last
//
// A byte enters an input register, is decoded against the parser state and
// its one to three events, if any, are loaded into the result register. One
// byte per cycle while rsp_stall is low and each byte yields at most one
// event; the events of a byte go out one by one and hold back the next byte
// that has events. Reset (synchronous) clears the parser state to line start
// and empties both registers. A stalled result port backs up into req_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_line_tokenizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kvlt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kvlt_pkg::rsp_type rsp_data
);
   import kvlt_pkg::*;

   logic       in_valid_ff, in_valid_in;
   req_type    in_ff;
   logic [3:0] state_ff, state_in;
   chain_type  chain;
   logic       free;
   logic       in_take;
   logic       req_take;

   // Decode the held byte against the current state.
   kvlt_decode u_decode (
      .item  (in_ff),
      .state (state_ff),
      .chain (chain)
   );

   // The held byte moves on when it has no events or the chain slot is free.
   assign in_take   = in_valid_ff && ((chain.count == 2'd0) || free);
   assign req_stall = in_valid_ff && !in_take;
   assign req_take  = req_valid && !req_stall;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
      state_in = in_take ? chain.next_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= ST_LINE_START;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
   end

   // Result register and event sequencing.
   kvlt_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .load      (in_take && (chain.count != 2'd0)),
      .chain     (chain),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An end command always returns the parser to line start.
   a_end_home: assert property (@(posedge clock) disable iff (reset)
      (in_take && in_ff.command == CMD_END) |=> (state_ff == ST_LINE_START))
      else $error("end command did not return to line start");

   // The commit state is transient and never held between bytes.
   a_no_commit_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff <= ST_AFTER_VALUE)
      else $error("parser state left the reachable range");

   // An end command always yields at least one event.
   a_end_events: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_ff.command == CMD_END) |-> (chain.count != 2'd0))
      else $error("end command produced no line reset");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key/value line tokenizer. Text bytes and end
// commands are pushed through the request channel while a scoreboard tracks
// the parser state and predicts every event, which is then checked against
// the result channel. Directed lines come first, then random lines under
// several idle and stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kvlt_pkg::*;

   // Tracks the parser state and holds the events still to come.
   class token_scoreboard;
      rsp_type    expected_events[$];
      logic [3:0] line_state;
      int         chain_start;
      int         mismatches;

      function new();
         line_state  = ST_LINE_START;
         chain_start = 0;
         mismatches  = 0;
      endfunction

      function bit is_name_byte(input logic [7:0] c);
         return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
      endfunction

      function bit is_blank_byte(input logic [7:0] c);
         return (c == CH_SPACE) || (c == CH_TAB);
      endfunction

      function bit is_line_end(input logic [7:0] c);
         return (c == CH_CR) || (c == CH_LF);
      endfunction

      // A single item never yields more than three events.
      function void add_event(input logic [2:0] ev, input logic [7:0] ch);
         rsp_type e;
         if (expected_events.size() - chain_start < 3) begin
            e.event_res = ev;
            e.char_out  = ch;
            e.last      = 1'b0;
            expected_events = {expected_events, e};
         end
      endfunction

      // Predicts the events of one accepted item and advances the state.
      function void note_item(input req_type it);
         logic [7:0] c;
         bit         again;
         int         guard;
         c = it.char_in;
         chain_start = expected_events.size();
         if (it.command == CMD_END) begin
            if (line_state == ST_IN_PLAIN || line_state == ST_AFTER_VALUE)
               add_event(EV_COMMIT, 8'h00);
            add_event(EV_LINE_RST, 8'h00);
            line_state = ST_LINE_START;
         end else begin
            again = 1'b1;
            for (guard = 0; again && guard < 6; guard++) begin
               again = 1'b0;
               case (line_state)
                  ST_LINE_START: begin
                     if (c == CH_SEMI) begin
                        line_state = ST_SKIP_LINE;
                     end else if (is_name_byte(c)) begin
                        add_event(EV_NAME_CHAR, c);
                        line_state = ST_IN_NAME;
                     end
                  end
                  ST_SKIP_LINE: begin
                     if (is_line_end(c)) begin
                        add_event(EV_LINE_RST, 8'h00);
                        line_state = ST_LINE_START;
                     end
                  end
                  ST_IN_NAME: begin
                     if (is_name_byte(c)) begin
                        add_event(EV_NAME_CHAR, c);
                     end else if (is_blank_byte(c)) begin
                        line_state = ST_AFTER_NAME;
                     end else if (c == CH_EQ) begin
                        line_state = ST_BEFORE_VALUE;
                     end else begin
                        line_state = ST_SKIP_LINE;
                        again = 1'b1;
                     end
                  end
                  ST_AFTER_NAME: begin
                     if (c == CH_EQ) begin
                        line_state = ST_BEFORE_VALUE;
                     end else if (!is_blank_byte(c)) begin
                        line_state = ST_SKIP_LINE;
                        again = 1'b1;
                     end
                  end
                  ST_BEFORE_VALUE: begin
                     if (is_name_byte(c)) begin
                        line_state = ST_IN_PLAIN;
                        again = 1'b1;
                     end else if (c == CH_QUOTE) begin
                        line_state = ST_IN_QUOTED;
                     end else if (is_line_end(c)) begin
                        add_event(EV_VALUES_RST, 8'h00);
                        line_state = ST_COMMIT;
                        again = 1'b1;
                     end else if (!is_blank_byte(c)) begin
                        line_state = ST_SKIP_LINE;
                        again = 1'b1;
                     end
                  end
                  ST_IN_QUOTED: begin
                     if (is_line_end(c)) begin
                        line_state = ST_SKIP_LINE;
                        again = 1'b1;
                     end else if (c == CH_QUOTE) begin
                        add_event(EV_NEXT_VALUE, 8'h00);
                        line_state = ST_AFTER_VALUE;
                     end else begin
                        add_event(EV_VALUE_CHAR, c);
                     end
                  end
                  ST_IN_PLAIN: begin
                     if (is_line_end(c)) begin
                        add_event(EV_NEXT_VALUE, 8'h00);
                        line_state = ST_COMMIT;
                        again = 1'b1;
                     end else if (c == CH_COMMA) begin
                        add_event(EV_NEXT_VALUE, 8'h00);
                        line_state = ST_BEFORE_VALUE;
                     end else if (is_blank_byte(c)) begin
                        add_event(EV_NEXT_VALUE, 8'h00);
                        line_state = ST_AFTER_VALUE;
                     end else begin
                        add_event(EV_VALUE_CHAR, c);
                     end
                  end
                  ST_AFTER_VALUE: begin
                     if (is_line_end(c)) begin
                        line_state = ST_COMMIT;
                        again = 1'b1;
                     end else if (c == CH_COMMA) begin
                        line_state = ST_BEFORE_VALUE;
                     end else if (!is_blank_byte(c)) begin
                        line_state = ST_SKIP_LINE;
                        again = 1'b1;
                     end
                  end
                  ST_COMMIT: begin
                     add_event(EV_COMMIT, 8'h00);
                     line_state = ST_SKIP_LINE;
                     again = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         if (expected_events.size() > chain_start)
            expected_events[expected_events.size() - 1].last = 1'b1;
      endfunction

      // Compares one accepted event with the oldest prediction.
      function void check_event(input rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: unexpected event %0d char %h last %0b",
                        got.event_res, got.char_out, got.last);
         end else begin
            want = expected_events.pop_front();
            if (got.event_res !== want.event_res || got.char_out !== want.char_out ||
                got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: event exp %0d got %0d, char exp %h got %h, ",
                            "last exp %0b got %0b"},
                           want.event_res, got.event_res, want.char_out, got.char_out,
                           want.last, got.last);
            end
         end
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   bit hold_armed    = 1'b0;
   int items_sent    = 0;

   token_scoreboard sb;

   key_value_line_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard limit on the run time.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Receiver: random stalls, or a long hold-off once it is armed.
   always @(posedge clock) begin
      if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left  = 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Both handshakes are observed on the values just before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_item(req_data);
         if (rsp_valid && !rsp_stall)
            sb.check_event(rsp_data);
      end
   end

   // Offers one item after random idle cycles and waits until it is taken.
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] c);
      req_type it;
      it.command = CMD_TEXT;
      it.char_in = c;
      send_item(it);
   endtask

   // The byte that travels with an end command is random and must be ignored.
   task automatic send_end();
      req_type it;
      it.command = CMD_END;
      it.char_in = 8'($urandom_range(255));
      send_item(it);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   task automatic send_blanks();
      repeat ($urandom_range(1, 2))
         send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
   endtask

   // Holds the sender until every predicted event has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] rand_name_char();
      int r;
      r = $urandom_range(62);
      if (r < 26)
         return 8'h61 + 8'(r);
      else if (r < 52)
         return 8'h41 + 8'(r - 26);
      else if (r < 62)
         return 8'h30 + 8'(r - 52);
      return CH_UNDER;
   endfunction

   // Any byte but a line end, optionally also no quote or no separator.
   function automatic logic [7:0] rand_other_byte(input bit no_quote, input bit no_sep);
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255));
      end while (c == CH_CR || c == CH_LF || (no_quote && c == CH_QUOTE) ||
                 (no_sep && (c == CH_COMMA || c == CH_SPACE || c == CH_TAB)));
      return c;
   endfunction

   // One random line: mostly name=value lines, plus comments, noise and ends.
   task automatic send_random_line();
      int kind;
      int nvals;
      int sep;
      logic [7:0] eol;
      kind = $urandom_range(99);
      eol  = $urandom_range(1) ? CH_CR : CH_LF;
      if (kind < 10) begin
         send_byte(CH_SEMI);
         repeat ($urandom_range(0, 5))
            send_byte(rand_other_byte(1'b0, 1'b0));
         send_byte(eol);
      end else if (kind < 20) begin
         repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(255)));
      end else if (kind < 28) begin
         send_end();
      end else begin
         repeat ($urandom_range(1, 4))
            send_byte(rand_name_char());
         if ($urandom_range(3) == 0)
            send_blanks();
         send_byte(CH_EQ);
         if ($urandom_range(1))
            send_blanks();
         nvals = $urandom_range(0, 3);
         for (int k = 0; k < nvals; k++) begin
            if (k > 0) begin
               sep = $urandom_range(2);
               if (sep == 0) begin
                  send_byte(CH_COMMA);
               end else if (sep == 1) begin
                  send_blanks();
               end else begin
                  send_blanks();
                  send_byte(CH_COMMA);
                  send_blanks();
               end
            end
            if ($urandom_range(1)) begin
               send_byte(rand_name_char());
               repeat ($urandom_range(0, 3))
                  send_byte($urandom_range(4) == 0 ? rand_other_byte(1'b0, 1'b1)
                                                   : rand_name_char());
            end else begin
               send_byte(CH_QUOTE);
               repeat ($urandom_range(0, 4))
                  send_byte(rand_other_byte(1'b1, 1'b0));
               // Now and then the line breaks inside the quotes.
               if ($urandom_range(9) == 0) begin
                  send_byte(eol);
                  return;
               end
               send_byte(CH_QUOTE);
            end
         end
         case ($urandom_range(9))
            0: begin
               send_byte(8'($urandom_range(255)));
               send_byte(eol);
            end
            1: begin
               send_end();
            end
            default: begin
               if ($urandom_range(3) == 0)
                  send_blanks();
               send_byte(eol);
            end
         endcase
      end
   endtask

   task automatic run_phase(input int idle, input int stall, input int count, input bit hold);
      int target;
      send_idle_pct = idle;
      stall_pct     = stall;
      target        = items_sent + count;
      if (hold)
         hold_armed = 1'b1;
      while (items_sent < target)
         send_random_line();
      wait_drained();
   endtask

   // Main sequence: reset, directed lines, random phases, final check.
   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty value right after the equals sign.
      send_text("k=\n");
      // Comment line holding the extreme byte values.
      send_byte(CH_SEMI);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(CH_CR);
      // Line end inside a quoted value drops the line.
      send_text("_=\"");
      send_byte(8'h00);
      send_byte(CH_LF);
      // End of data inside a plain value commits it.
      send_text("Z=9");
      send_end();
      // End of data after a closed quoted value commits it too.
      send_text("x=\"\"");
      send_end();
      // Bad line, then end of data while skipping: line reset only.
      send_text("b\t");
      send_byte(8'hFF);
      send_end();
      wait_drained();

      // No idling, with one long hold-off of the receiver.
      run_phase(0, 0, 100, 1'b1);
      run_phase(82, 0, 100, 1'b0);
      run_phase(0, 82, 100, 1'b0);
      run_phase(9, 9, 100, 1'b0);

      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
